### design/ols_pkg.sv
`default_nettype none

package ols_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);

    // Field widths
    localparam int CNT_W    = 5;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;

    // Stream packing
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_UPDATE = 2'd3
    } ols_req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } ols_status_t;

    // Controller to datapath
    typedef struct packed {
        logic        load;
        logic        start_up;
        logic        start_down;
        logic        start_scan;
        logic        shift_up;
        logic        shift_down;
        logic        scan_next;
        logic        scan_write;
        logic        finish;
        ols_status_t status;
        logic        found;
    } ols_cmd_t;

    // Datapath to controller
    typedef struct packed {
        ols_req_t req;
        logic     ins_badpos;
        logic     ins_full;
        logic     del_badpos;
        logic     up_last;
        logic     down_last;
        logic     scan_end;
        logic     scan_hit;
    } ols_sts_t;

endpackage

`default_nettype wire

### design/ols_dp.sv
`default_nettype none

module ols_dp
    import ols_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [1:0]         in_req,
    input  wire logic [POS_W-1:0]   in_pos,
    input  wire logic [VAL_W-1:0]   in_value,
    input  wire logic [VAL_W-1:0]   in_rep,
    input  wire ols_cmd_t           cmd,
    output ols_sts_t                sts,
    output logic [1:0]              out_status,
    output logic [POS_W-1:0]        out_fpos,
    output logic [CNT_W-1:0]        out_count
);

    logic [VAL_W-1:0] list_store_reg [CAPACITY];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    ols_req_t         req_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] rep_reg;
    logic [CNT_W-1:0] idx_reg;

    ols_status_t      status_out_reg;
    logic [POS_W-1:0] fpos_out_reg;
    logic [CNT_W-1:0] count_out_reg;

    logic [CNT_W-1:0] idx_m1;
    logic [CNT_W-1:0] idx_p1;
    logic [POS_W-1:0] pos_m1;
    logic [IDX_W-1:0] rd_addr;
    logic [VAL_W-1:0] rd_data;
    logic [CNT_W:0]   count_p1;

    assign idx_m1   = idx_reg - CNT_W'(1);
    assign idx_p1   = idx_reg + CNT_W'(1);
    assign pos_m1   = pos_reg - POS_W'(1);
    assign count_p1 = {1'b0, count_reg} + (CNT_W+1)'(1);

    // Single read port: shift-up reads the entry below the write slot
    assign rd_addr = cmd.shift_up ? idx_m1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign rd_data = list_store_reg[rd_addr];

    always_comb
    begin
        sts.req        = req_reg;
        sts.ins_badpos = (pos_reg == '0) || ({1'b0, pos_reg} > count_p1);
        sts.ins_full   = (count_reg >= CNT_W'(CAPACITY));
        sts.del_badpos = (pos_reg == '0) || (pos_reg > count_reg);
        sts.up_last    = (idx_reg < pos_reg);
        sts.down_last  = (idx_reg >= count_reg);
        sts.scan_end   = (idx_reg >= count_reg);
        sts.scan_hit   = (idx_reg < count_reg) && (rd_data == val_reg);
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.shift_up && sts.up_last)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.shift_down && sts.down_last)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= ols_req_t'(in_req);
            pos_reg <= in_pos;
            val_reg <= in_value;
            rep_reg <= in_rep;
        end

        if (cmd.start_up)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.start_down)
        begin
            idx_reg <= pos_reg;
        end
        else if (cmd.start_scan)
        begin
            idx_reg <= '0;
        end
        else if (cmd.shift_up && !sts.up_last)
        begin
            idx_reg <= idx_m1;
        end
        else if ((cmd.shift_down && !sts.down_last) || cmd.scan_next)
        begin
            idx_reg <= idx_p1;
        end

        // Move one entry per cycle; drop the new value in once the gap is open
        if (cmd.shift_up)
        begin
            if (!sts.up_last)
            begin
                list_store_reg[idx_reg[IDX_W-1:0]] <= rd_data;
            end
            else
            begin
                list_store_reg[pos_m1[IDX_W-1:0]] <= val_reg;
            end
        end
        else if (cmd.shift_down && !sts.down_last)
        begin
            list_store_reg[idx_m1[IDX_W-1:0]] <= rd_data;
        end
        else if (cmd.scan_write && req_reg == REQ_UPDATE)
        begin
            list_store_reg[idx_reg[IDX_W-1:0]] <= rep_reg;
        end

        if (cmd.finish)
        begin
            status_out_reg <= cmd.status;
            fpos_out_reg   <= cmd.found ? idx_p1 : '0;
            count_out_reg  <= count_reg;
        end
    end

    assign out_status = status_out_reg;
    assign out_fpos   = fpos_out_reg;
    assign out_count  = count_out_reg;

endmodule

`default_nettype wire

### design/ols_ctrl.sv
`default_nettype none

module ols_ctrl
    import ols_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire ols_sts_t sts,
    output ols_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_SCAN,
        S_REPORT
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    ols_status_t status_reg;
    ols_status_t status_next;
    logic        found_reg;
    logic        found_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        found_next  = found_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        cmd.found   = found_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                found_next  = 1'b0;
                status_next = ST_OK;
                case (sts.req)
                    REQ_INSERT:
                    begin
                        if (sts.ins_badpos)
                        begin
                            status_next = ST_BADPOS;
                            state_next  = S_REPORT;
                        end
                        else if (sts.ins_full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_REPORT;
                        end
                        else
                        begin
                            cmd.start_up = 1'b1;
                            state_next   = S_SHIFT_UP;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (sts.del_badpos)
                        begin
                            status_next = ST_BADPOS;
                            state_next  = S_REPORT;
                        end
                        else
                        begin
                            cmd.start_down = 1'b1;
                            state_next     = S_SHIFT_DOWN;
                        end
                    end
                    default:
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = S_SCAN;
                    end
                endcase
            end

            S_SHIFT_UP:
            begin
                cmd.shift_up = 1'b1;
                if (sts.up_last)
                begin
                    state_next = S_REPORT;
                end
            end

            S_SHIFT_DOWN:
            begin
                cmd.shift_down = 1'b1;
                if (sts.down_last)
                begin
                    state_next = S_REPORT;
                end
            end

            S_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.scan_write = 1'b1;
                    found_next     = 1'b1;
                    state_next     = S_REPORT;
                end
                else if (sts.scan_end)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_REPORT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end

            S_REPORT:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_OK;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### design/ordered_list_store.sv
// Ordered list store: holds up to CAPACITY (16) signed 32-bit values in
// 1-based positions plus an entry count, and serves one request at a time
// over a streaming input: insert (shift later entries up), delete (shift
// later entries down), search (first position of a value) and update (replace
// the first match). Every request returns exactly one result transaction with
// a status, a found position and the entry count after the request. A request
// is taken and decoded, then walks the stored entries one per cycle through a
// single register-file read port (range and full errors skip the walk), and
// is reported once the walk ends. The input is ready again as soon as the
// result sits in the output register, so a new request can be decoded while
// the previous result still waits for the downstream side.
`default_nettype none

module ordered_list_store
    import ols_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [4:0] position, [36:5] value, [68:37] replacement, [71:69] zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [4:0] found_position, [9:5] entry_count, [15:10] zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // [1:0] status
    output logic [1:0]                 m_axis_tuser
);

    ols_cmd_t         cmd;
    ols_sts_t         sts;
    logic [POS_W-1:0] out_fpos;
    logic [CNT_W-1:0] out_count;

    // Sequencer: accept, decode, walk the list, report
    ols_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // List storage, count, walk index and result register
    ols_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_req     (s_axis_tuser),
        .in_pos     (s_axis_tdata[POS_W-1:0]),
        .in_value   (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
        .in_rep     (s_axis_tdata[POS_W+2*VAL_W-1:POS_W+VAL_W]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (m_axis_tuser),
        .out_fpos   (out_fpos),
        .out_count  (out_count)
    );

    assign m_axis_tdata = {(OUT_DATA_W-POS_W-CNT_W)'(0), out_count, out_fpos};

`ifndef SYNTHESIS
    // The count reported never passes the list capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[POS_W+CNT_W-1:POS_W] <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    // A nonzero found position only comes with an ok status
    a_fpos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[POS_W-1:0] != '0) |-> (m_axis_tuser == ST_OK))
        else $error("found position without ok status");

    // A full status means the list really holds CAPACITY entries
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL)
            |-> (m_axis_tdata[POS_W+CNT_W-1:POS_W] == CNT_W'(CAPACITY)))
        else $error("full status with list not full");

    // One request at a time: ready drops right after a transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while busy");
`endif

endmodule

`default_nettype wire

### bench/ordered_list_store_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of ordered_list_store. Keeps its own copy of the
// list and the entry count, computes each request's reply when the request
// transaction is taken, and compares reply transactions in order.
module ordered_list_store_checker
    import ols_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [1:0]            s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic [1:0]            m_axis_tuser,
    output int                         failures,
    output int                         outstanding
);

    typedef struct packed {
        ols_status_t      status;
        logic [POS_W-1:0] found_pos;
        logic [CNT_W-1:0] entry_count;
    } list_reply_t;

    logic signed [VAL_W-1:0] stored_values [CAPACITY];
    int                      stored_count;
    list_reply_t             pending_replies [$];

    // Apply one request to the shadow list and return the reply it earns.
    function automatic list_reply_t apply_list_request(
        input ols_req_t                req,
        input logic [POS_W-1:0]        pos,
        input logic signed [VAL_W-1:0] val,
        input logic signed [VAL_W-1:0] rep
    );
        list_reply_t reply;
        int          n;
        int          p;
        int          i;
        reply.status      = ST_OK;
        reply.found_pos   = '0;
        n                 = stored_count;
        p                 = int'(pos);
        case (req)
            REQ_INSERT:
            begin
                if (p < 1 || p > n + 1)
                    reply.status = ST_BADPOS;
                else if (n >= CAPACITY)
                    reply.status = ST_FULL;
                else
                begin
                    for (i = n; i >= p; i--)
                        stored_values[i] = stored_values[i-1];
                    stored_values[p-1] = val;
                    stored_count++;
                end
            end
            REQ_DELETE:
            begin
                if (p < 1 || p > n)
                    reply.status = ST_BADPOS;
                else
                begin
                    for (i = p; i < n; i++)
                        stored_values[i-1] = stored_values[i];
                    stored_count--;
                end
            end
            default:
            begin
                // search and update both act on the lowest matching position
                for (i = 0; i < n; i++)
                    if (reply.found_pos == '0 && stored_values[i] == val)
                        reply.found_pos = POS_W'(i + 1);
                if (reply.found_pos == '0)
                    reply.status = ST_NOTFOUND;
                else if (req == REQ_UPDATE)
                    stored_values[reply.found_pos-1] = rep;
            end
        endcase
        reply.entry_count = CNT_W'(stored_count);
        return reply;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        list_reply_t want;
        if (!rst_n)
        begin
            stored_count = 0;
            failures     = 0;
            pending_replies.delete();
        end
        else
        begin
            // Push first; the reply then pops the oldest request still waiting.
            if (s_axis_tvalid && s_axis_tready)
                pending_replies.push_back(apply_list_request(ols_req_t'(s_axis_tuser),
                    s_axis_tdata[4:0], s_axis_tdata[36:5], s_axis_tdata[68:37]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply transaction with no request waiting");
                    failures++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("found_position", want.found_pos, m_axis_tdata[4:0]);
                    check_field("entry_count", want.entry_count, m_axis_tdata[9:5]);
                end
            end
        end
        outstanding = pending_replies.size();
    end

endmodule

### bench/ordered_list_store_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for ordered_list_store. The checker beside the block
// does all prediction and comparison; this module only offers requests, drives
// the reply side's ready, and decides pass or fail.
module ordered_list_store_tb;
    import ols_pkg::*;

    localparam int RANDOM_ITEMS  = 1100;
    localparam int PHASE_LEN     = 40;
    localparam int STALL_CYCLES  = 300;
    localparam int DRAIN_CYCLES  = 40;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_LOOKUP} mix_phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    int                    failures;
    int                    outstanding;

    // calm: no idling on either side; stall_request: ask the reply side to hold off
    bit                      calm;
    bit                      stall_request;
    logic signed [VAL_W-1:0] value_pool [8];

    ordered_list_store dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ordered_list_store_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("ordered_list_store verification failed");
        $finish;
    end

    // Reply side: random backpressure, a calm stretch, and one long hold-off
    // so the block's output register fills and the request side stalls.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                stall_request = 1'b0;
            end
            else
                m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
        end
    end

    // Offer one request at a falling edge, hold it until taken, then maybe
    // idle so gaps land on every phase of the block's work.
    task automatic offer_request(
        input ols_req_t                req,
        input logic [POS_W-1:0]        pos,
        input logic signed [VAL_W-1:0] val,
        input logic signed [VAL_W-1:0] rep
    );
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {3'b000, rep, val, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Drop valid and wait at falling edges until every reply has come back.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Mostly pool values so search and update hit and duplicates build up.
    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 75)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    initial
    begin : stimulus
        int         i;
        int         roll;
        mix_phase_t phase;
        ols_req_t   req;
        logic [POS_W-1:0] pos;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_INSERT;
        calm          = 1'b0;
        stall_request = 1'b0;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        for (i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-list errors, insert at front, end and middle, fill
        // to capacity with duplicates, full and range errors, lookups, deletes.
        offer_request(REQ_SEARCH, 5'd0, 32'sd5, 32'sd0);
        offer_request(REQ_DELETE, 5'd1, 32'sd0, 32'sd0);
        offer_request(REQ_INSERT, 5'd0, 32'sd9, 32'sd0);
        offer_request(REQ_INSERT, 5'd2, 32'sd9, 32'sd0);
        offer_request(REQ_INSERT, 5'd1, 32'sh8000_0000, 32'sd0);
        offer_request(REQ_INSERT, 5'd2, 32'sh7fff_ffff, 32'sd0);
        offer_request(REQ_INSERT, 5'd1, 32'sd0, 32'sd0);
        offer_request(REQ_INSERT, 5'd2, -32'sd1, 32'sd0);
        for (i = 4; i < CAPACITY; i++)
            offer_request(REQ_INSERT, POS_W'(i + 1), i % 3, 32'sd0);
        offer_request(REQ_INSERT, 5'd17, 32'sd3, 32'sd0);
        offer_request(REQ_INSERT, 5'd18, 32'sd3, 32'sd0);
        offer_request(REQ_UPDATE, 5'd0, 32'sd2, 32'sh7fff_ffff);
        offer_request(REQ_UPDATE, 5'd31, 32'sd12345, $urandom);
        offer_request(REQ_DELETE, 5'd0, 32'sd0, 32'sd0);
        offer_request(REQ_DELETE, 5'd17, 32'sd0, 32'sd0);
        offer_request(REQ_DELETE, 5'd16, 32'sd0, 32'sd0);
        offer_request(REQ_DELETE, 5'd1, 32'sd0, 32'sd0);
        pause_until_drained();

        // Random: phases that lean toward filling, draining, a mix or lookups, with
        // some noise requests carrying any position in the field's range.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase = mix_phase_t'((i / PHASE_LEN) % 4);
            calm  = (i >= 500 && i < 700);
            if (i == 800)
                stall_request = 1'b1;
            if (i == 300)
                pause_until_drained();

            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 10)
            begin
                case (roll % 4)
                    0:       req = REQ_INSERT;
                    1:       req = REQ_DELETE;
                    2:       req = REQ_SEARCH;
                    default: req = REQ_UPDATE;
                endcase
                offer_request(req, POS_W'($urandom_range(0, 31)), $urandom, $urandom);
            end
            else
            begin
                case (phase)
                    PH_FILL:   req = roll < 60 ? REQ_INSERT : roll < 70 ? REQ_DELETE :
                                     roll < 85 ? REQ_SEARCH : REQ_UPDATE;
                    PH_DRAIN:  req = roll < 15 ? REQ_INSERT : roll < 70 ? REQ_DELETE :
                                     roll < 85 ? REQ_SEARCH : REQ_UPDATE;
                    PH_MIXED:  req = roll < 35 ? REQ_INSERT : roll < 60 ? REQ_DELETE :
                                     roll < 80 ? REQ_SEARCH : REQ_UPDATE;
                    default:   req = roll < 15 ? REQ_INSERT : roll < 25 ? REQ_DELETE :
                                     roll < 60 ? REQ_SEARCH : REQ_UPDATE;
                endcase
                // Favor low positions, which stay valid as the list moves.
                if ($urandom_range(0, 1))
                    pos = POS_W'($urandom_range(1, 4));
                else
                    pos = (req == REQ_INSERT) ? POS_W'($urandom_range(1, CAPACITY + 1))
                                              : POS_W'($urandom_range(1, CAPACITY));
                offer_request(req, pos, pick_value(), pick_value());
            end
        end

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0 && outstanding == 0)
            $display("ordered_list_store verification clean");
        else
            $display("ordered_list_store verification failed");
        $finish;
    end

endmodule

### sim.f
design/ols_pkg.sv
design/ols_dp.sv
design/ols_ctrl.sv
design/ordered_list_store.sv
bench/ordered_list_store_checker.sv
bench/ordered_list_store_tb.sv
